// ===== src/led_blink_pattern_generator_defines.svh =====
// Assertion macros for the LED blink pattern generator checker.
// Each macro expects clk and rst_n in scope.
`ifndef LED_BLINK_PATTERN_GENERATOR_DEFINES_SVH
`define LED_BLINK_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define LBPG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LBPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lbpg_pkg.sv =====
`timescale 1ns / 1ps

package lbpg_pkg;

    localparam int unsigned PAT_W     = 3;
    localparam int unsigned MS_W      = 10;
    localparam int unsigned ELAPSED_W = 11;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    typedef logic [PAT_W-1:0]     pat_t;
    typedef logic [MS_W-1:0]      ms_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;
    typedef logic [STEP_W-1:0]    step_t;

    localparam pat_t PAT_OFF    = 3'd0;
    localparam pat_t PAT_ON     = 3'd1;
    localparam pat_t PAT_FAST   = 3'd2;
    localparam pat_t PAT_SLOW   = 3'd3;
    localparam pat_t PAT_DOUBLE = 3'd4;
    localparam pat_t PAT_TRIPLE = 3'd5;
    localparam pat_t PAT_SOS    = 3'd6;
    localparam pat_t PAT_RAPID  = 3'd7;

    localparam logic REG_PATTERN    = 1'b0;
    localparam logic REG_ACTIVE_LOW = 1'b1;

    localparam elapsed_t ELAPSED_MAX = 11'd2047;

    localparam ms_t PERIOD_FAST  = 10'd200;
    localparam ms_t PERIOD_SLOW  = 10'd1000;
    localparam ms_t PERIOD_RAPID = 10'd80;

    localparam ms_t DBL_TIMES [4] = '{10'd150, 10'd150, 10'd150, 10'd600};
    localparam ms_t TRI_TIMES [6] = '{10'd150, 10'd150, 10'd150, 10'd150, 10'd150, 10'd600};
    localparam ms_t SOS_TIMES [18] = '{
        10'd100, 10'd100, 10'd100, 10'd100, 10'd100, 10'd300,
        10'd300, 10'd100, 10'd300, 10'd100, 10'd300, 10'd300,
        10'd100, 10'd100, 10'd100, 10'd100, 10'd100, 10'd700
    };

    localparam step_t DBL_LEN = 5'd4;
    localparam step_t TRI_LEN = 5'd6;
    localparam step_t SOS_LEN = 5'd18;

    function automatic ms_t toggle_period(input pat_t pat);
        case (pat)
            PAT_FAST: toggle_period = PERIOD_FAST;
            PAT_SLOW: toggle_period = PERIOD_SLOW;
            default:  toggle_period = PERIOD_RAPID;
        endcase
    endfunction

    function automatic step_t step_len(input pat_t pat);
        case (pat)
            PAT_DOUBLE: step_len = DBL_LEN;
            PAT_TRIPLE: step_len = TRI_LEN;
            default:    step_len = SOS_LEN;
        endcase
    endfunction

    // Reduce a stored step modulo the table length.
    function automatic step_t step_wrap(input pat_t pat, input step_t idx);
        step_t r;
        r = idx;
        case (pat)
            PAT_DOUBLE: r = {3'b000, idx[1:0]};
            PAT_TRIPLE:
            begin
                if (r >= 5'd24) r = r - 5'd24;
                if (r >= 5'd12) r = r - 5'd12;
                if (r >= TRI_LEN) r = r - TRI_LEN;
            end
            default:
            begin
                if (r >= SOS_LEN) r = r - SOS_LEN;
            end
        endcase
        return r;
    endfunction

    function automatic ms_t step_time(input pat_t pat, input step_t cur);
        case (pat)
            PAT_DOUBLE: step_time = DBL_TIMES[cur[1:0]];
            PAT_TRIPLE: step_time = TRI_TIMES[cur[2:0]];
            default:    step_time = SOS_TIMES[cur];
        endcase
    endfunction

endpackage

// ===== src/led_blink_pattern_generator.sv =====
`timescale 1ns / 1ps

// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------
// in       | in_valid  | in_stall  | ms_advance
// out      | out_valid | out_stall | led_on, pin_level
// config   | psel/penable/pwrite, pready tied high | paddr, pwdata, prdata
//
// One item per cycle sustained while out_stall is low; an accepted input goes to the
// input register, then through one add/compare/table step into the result register.
// rst_n clears valid flags, configuration and state: LED off, pattern off.
// A stalled result holds the result register; the input register fills behind
// it and in_stall rises only when both are occupied.

module led_blink_pattern_generator
    import lbpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [9:0]        ms_advance,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              led_on,
    output logic              pin_level,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic     in_valid_reg;
    ms_t      ms_reg;
    logic     out_valid_reg;
    logic     led_out_reg;
    logic     pin_out_reg;
    pat_t     pattern_reg;
    logic     active_low_reg;
    logic     led_state_reg;
    elapsed_t elapsed_reg;
    step_t    step_reg;

    logic     cfg_write;
    logic     pat_write;
    pat_t     pat_wdata;
    logic     s2_ready;
    logic     s1_fire;
    logic     in_fire;

    logic [ELAPSED_W:0] sum_ext;
    elapsed_t elapsed_sat;
    step_t    cur;
    step_t    cur_p1;
    step_t    nxt;
    logic     led_next;
    elapsed_t elapsed_next;
    step_t    step_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pat_wdata = pwdata[PAT_W-1:0];
    assign pat_write = cfg_write && (paddr[2] == REG_PATTERN);

    assign s2_ready = !out_valid_reg || !out_stall;
    assign s1_fire  = in_valid_reg && s2_ready;
    assign in_stall = in_valid_reg && !s2_ready;
    assign in_fire  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign led_on    = led_out_reg;
    assign pin_level = pin_out_reg;

    always_comb
    begin
        if (paddr[2] == REG_ACTIVE_LOW)
        begin
            prdata = {{(APB_DW-1){1'b0}}, active_low_reg};
        end
        else
        begin
            prdata = {{(APB_DW-PAT_W){1'b0}}, pattern_reg};
        end
    end

    always_comb
    begin
        sum_ext      = {1'b0, elapsed_reg} + {{(ELAPSED_W+1-MS_W){1'b0}}, ms_reg};
        elapsed_sat  = (sum_ext > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX
                                                        : sum_ext[ELAPSED_W-1:0];
        cur          = step_wrap(pattern_reg, step_reg);
        cur_p1       = cur + 5'd1;
        nxt          = (cur_p1 == step_len(pattern_reg)) ? '0 : cur_p1;
        led_next     = led_state_reg;
        elapsed_next = elapsed_sat;
        step_next    = step_reg;
        unique case (pattern_reg) inside
            PAT_OFF:
            begin
                led_next = 1'b0;
            end
            PAT_ON:
            begin
                led_next = 1'b1;
            end
            PAT_FAST, PAT_SLOW, PAT_RAPID:
            begin
                if (elapsed_sat >= {1'b0, toggle_period(pattern_reg)})
                begin
                    led_next     = !led_state_reg;
                    elapsed_next = '0;
                end
            end
            default:
            begin
                if (elapsed_sat >= {1'b0, step_time(pattern_reg, cur)})
                begin
                    step_next    = nxt;
                    led_next     = !nxt[0];
                    elapsed_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pattern_reg    <= PAT_OFF;
            active_low_reg <= 1'b0;
            led_state_reg  <= 1'b0;
            elapsed_reg    <= '0;
            step_reg       <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write && (paddr[2] == REG_ACTIVE_LOW))
            begin
                active_low_reg <= pwdata[0];
            end

            if (pat_write && (pat_wdata != pattern_reg))
            begin
                pattern_reg <= pat_wdata;
                elapsed_reg <= '0;
                step_reg    <= '0;
            end
            else if (s1_fire)
            begin
                led_state_reg <= led_next;
                elapsed_reg   <= elapsed_next;
                step_reg      <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ms_reg <= ms_advance;
        end
        if (s1_fire)
        begin
            led_out_reg <= led_next;
            pin_out_reg <= led_next ^ active_low_reg;
        end
    end

endmodule

// ===== src/lbpg_checker.sv =====
`timescale 1ns / 1ps

`include "led_blink_pattern_generator_defines.svh"

module lbpg_checker
    import lbpg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic              led_on,
    input logic              pin_level,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic              pready,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata
);

    logic wr;
    logic active_low_reg;
    pat_t pattern_reg;

    assign wr = psel && penable && pwrite && pready;

    // Track register contents from the bus.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg <= 1'b0;
            pattern_reg    <= PAT_OFF;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_ACTIVE_LOW)
            begin
                active_low_reg <= pwdata[0];
            end
            else
            begin
                pattern_reg <= pwdata[PAT_W-1:0];
            end
        end
    end

    `LBPG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(led_on) && $stable(pin_level), "stalled result changed")
    `LBPG_ASSERT_IMPL(a_polarity, out_valid, pin_level == (led_on ^ active_low_reg), "pin level does not follow polarity")
    `LBPG_ASSERT_IMPL(a_forced_off, out_valid && (pattern_reg == PAT_OFF), !led_on, "LED lit with pattern off")
    `LBPG_ASSERT_IMPL(a_forced_on, out_valid && (pattern_reg == PAT_ON), led_on, "LED dark with pattern on")

endmodule

bind led_blink_pattern_generator lbpg_checker u_lbpg_checker (.*);

// ===== tb/sv/led_blink_pattern_generator_checker.sv =====
`timescale 1ns / 1ps

module led_blink_pattern_generator_checker
    import lbpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [9:0]        ms_advance,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              led_on,
    input  logic              pin_level,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                fail_count,
    output int                lamps_pending,
    output int                lamps_checked
);

    typedef struct packed {
        logic led;
        logic pin;
    } lamp_t;

    lamp_t       lamp_q[$];
    lamp_t       lamp_exp;
    pat_t        cur_pat;
    logic        cur_active_low;
    logic        lit;
    int unsigned elapsed_cnt;
    int unsigned step_pos;

    function automatic int unsigned seq_len(input pat_t p);
        case (p)
            PAT_DOUBLE: return 4;
            PAT_TRIPLE: return 6;
            default:    return 18;
        endcase
    endfunction

    function automatic int unsigned seq_hold(input pat_t p, input int unsigned idx);
        case (p)
            PAT_DOUBLE: return (idx == 3) ? 600 : 150;
            PAT_TRIPLE: return (idx == 5) ? 600 : 150;
            default:
            begin
                case (idx)
                    5, 6, 8, 10, 11: return 300;
                    17:              return 700;
                    default:         return 100;
                endcase
            end
        endcase
    endfunction

    function automatic void blink_toggle(input int unsigned period);
        if (elapsed_cnt >= period)
        begin
            lit = ~lit;
            elapsed_cnt = 0;
        end
    endfunction

    function automatic void blink_sequence(input pat_t p);
        int unsigned len;
        int unsigned cur;
        int unsigned nxt;
        len = seq_len(p);
        cur = step_pos % len;
        if (elapsed_cnt >= seq_hold(p, cur))
        begin
            nxt = (cur + 1) % len;
            step_pos = nxt;
            lit = (nxt % 2 == 0);
            elapsed_cnt = 0;
        end
    endfunction

    function automatic void advance_lamp(input ms_t adv);
        int unsigned sum;
        sum = elapsed_cnt + adv;
        elapsed_cnt = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum;
        case (cur_pat)
            PAT_OFF:    lit = 1'b0;
            PAT_ON:     lit = 1'b1;
            PAT_FAST:   blink_toggle(200);
            PAT_SLOW:   blink_toggle(1000);
            PAT_DOUBLE: blink_sequence(cur_pat);
            PAT_TRIPLE: blink_sequence(cur_pat);
            PAT_SOS:    blink_sequence(cur_pat);
            default:    blink_toggle(80);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_q.delete();
            cur_pat        = PAT_OFF;
            cur_active_low = 1'b0;
            lit            = 1'b0;
            elapsed_cnt    = 0;
            step_pos       = 0;
            fail_count     = 0;
            lamps_pending  = 0;
            lamps_checked  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (lamp_q.size() == 0)
                begin
                    $error("unexpected item: led_on=%0b pin_level=%0b", led_on, pin_level);
                    fail_count++;
                end
                else
                begin
                    lamp_exp = lamp_q.pop_front();
                    lamps_checked++;
                    if (led_on !== lamp_exp.led)
                    begin
                        $error("led_on: expected %0b, actual %0b", lamp_exp.led, led_on);
                        fail_count++;
                    end
                    if (pin_level !== lamp_exp.pin)
                    begin
                        $error("pin_level: expected %0b, actual %0b", lamp_exp.pin, pin_level);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_lamp(ms_advance);
                lamp_q.push_back('{led: lit, pin: lit ^ cur_active_low});
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_PATTERN)
                begin
                    if (pat_t'(pwdata[PAT_W-1:0]) != cur_pat)
                    begin
                        cur_pat     = pat_t'(pwdata[PAT_W-1:0]);
                        step_pos    = 0;
                        elapsed_cnt = 0;
                    end
                end
                else
                begin
                    cur_active_low = pwdata[0];
                end
            end
            lamps_pending = lamp_q.size();
        end
    end

endmodule

// ===== tb/sv/led_blink_pattern_generator_tb.sv =====
`timescale 1ns / 1ps

module led_blink_pattern_generator_tb;
    import lbpg_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [9:0]        ms_advance;
    logic              out_valid;
    logic              out_stall;
    logic              led_on;
    logic              pin_level;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int lamps_pending;
    int lamps_checked;

    int   items_sent;
    int   burst_left;
    int   phases;
    int   stall_mode;
    int   stall_timer;
    int   stall_tick;
    pat_t cur_pat;

    int unsigned edges [24] = '{79, 80, 81, 99, 100, 101, 149, 150, 151, 199, 200, 201,
                                299, 300, 301, 599, 600, 601, 699, 700, 701, 999, 1000, 1001};

    led_blink_pattern_generator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ms_advance (ms_advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .led_on     (led_on),
        .pin_level  (pin_level),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    led_blink_pattern_generator_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ms_advance    (ms_advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .led_on        (led_on),
        .pin_level     (pin_level),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .lamps_pending (lamps_pending),
        .lamps_checked (lamps_checked)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver: switch between no stall, random, periodic and heavy stall
    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(16, 96);
        end
        stall_timer--;
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= (stall_tick % 5 < 2);
            default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    task automatic reg_write(input logic idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random upper bits must be masked off by the block
    task automatic set_pattern(input pat_t p);
        reg_write(REG_PATTERN, {(APB_DW-PAT_W)'($urandom()), p});
        cur_pat = p;
    endtask

    task automatic set_polarity(input logic al);
        reg_write(REG_ACTIVE_LOW, {(APB_DW-1)'($urandom()), al});
    endtask

    task automatic send_update(input ms_t ms);
        int gap;
        in_valid   <= 1'b1;
        ms_advance <= ms;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
            if (gap > 0)
            begin
                in_valid   <= 1'b0;
                ms_advance <= ms_t'($urandom());
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // hold off until every item has been checked
    task automatic drain;
        in_valid <= 1'b0;
        while (lamps_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic ms_t pick_advance;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return ms_t'($urandom_range(0, 160));
        if (r < 75) return ms_t'(edges[$urandom_range(0, 23)]);
        if (r < 90) return ms_t'($urandom_range(0, 1023));
        if (r < 95) return '0;
        return '1;
    endfunction

    initial
    begin
        int n;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        ms_advance  = '0;
        out_stall   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        items_sent  = 0;
        burst_left  = 0;
        phases      = 0;
        stall_mode  = 0;
        stall_timer = 0;
        stall_tick  = 0;
        cur_pat     = PAT_OFF;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // off with counter saturation
        send_update(10'd1023);
        send_update(10'd1023);
        send_update(10'd1023);
        send_update(10'd0);
        drain();
        set_pattern(PAT_OFF);
        set_pattern(PAT_ON);
        set_polarity(1'b1);
        send_update(10'd0);
        send_update(10'd1023);
        drain();
        set_pattern(PAT_FAST);
        set_polarity(1'b0);
        send_update(10'd199);
        send_update(10'd1);
        send_update(10'd200);
        send_update(10'd1023);
        drain();
        set_pattern(PAT_SLOW);
        send_update(10'd999);
        send_update(10'd1);
        send_update(10'd1000);
        drain();
        set_pattern(PAT_DOUBLE);
        send_update(10'd150);
        send_update(10'd149);
        send_update(10'd100);
        drain();
        // same pattern again keeps step and elapsed time
        set_pattern(PAT_DOUBLE);
        send_update(10'd50);
        send_update(10'd600);
        drain();
        set_pattern(PAT_TRIPLE);
        set_polarity(1'b1);
        send_update(10'd150);
        send_update(10'd1023);
        drain();
        set_pattern(PAT_SOS);
        send_update(10'd100);
        send_update(10'd99);
        drain();
        set_pattern(PAT_RAPID);
        send_update(10'd79);
        send_update(10'd1);
        send_update(10'd80);
        drain();

        while (items_sent < 620)
        begin
            phases++;
            if ($urandom_range(0, 4) != 0)
                set_pattern(($urandom_range(0, 3) == 0) ? cur_pat : pat_t'($urandom_range(0, 7)));
            if ($urandom_range(0, 1) == 0)
                set_polarity(1'($urandom_range(0, 1)));
            n = $urandom_range(10, 60);
            repeat (n) send_update(pick_advance());
            drain();
        end

        while (lamps_pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("covered %0d time updates over %0d random settings of pattern and polarity",
                 items_sent, phases);
        $display("%0d LED items compared, %0d failures", lamps_checked, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/lbpg_pkg.sv
src/led_blink_pattern_generator.sv
src/lbpg_checker.sv
tb/sv/led_blink_pattern_generator_checker.sv
tb/sv/led_blink_pattern_generator_tb.sv
